/* src/text_mode_console_engine_core_defines.svh */
`ifndef TEXT_MODE_CONSOLE_ENGINE_CORE_DEFINES_SVH
`define TEXT_MODE_CONSOLE_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TMCE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TMCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tmce_pkg.sv */
package tmce_pkg;

    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int OFFSET_W = 11;
    localparam int CELL_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [2:0] OP_PUT_CHAR    = 3'd0;
    localparam logic [2:0] OP_MOVE_CURSOR = 3'd1;
    localparam logic [2:0] OP_PUT_AT      = 3'd2;
    localparam logic [2:0] OP_CLEAR       = 3'd3;
    localparam logic [2:0] OP_SCROLL      = 3'd4;
    localparam logic [2:0] OP_READ_CELL   = 3'd5;

    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHAR_SPACE     = 8'd32;

    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_COLOR = 1'b1;

    localparam logic [7:0] COLOR_RESET = 8'd7;

    typedef enum logic [3:0] {
        K_PUTC,
        K_NEWLINE,
        K_BACKSPACE,
        K_MOVE,
        K_PUTAT,
        K_CLEAR,
        K_SCROLL,
        K_READ,
        K_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         ch;
        logic [7:0]         color;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               in_range;
        logic [ROW_W-1:0]   lines;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_FILL,
        ST_DONE
    } back_state_t;

endpackage

/* src/tmce_front.sv */
module tmce_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    operation,
    input  logic [7:0]                    char_code,
    input  logic [7:0]                    cell_color,
    input  logic [tmce_pkg::COL_W-1:0]    column,
    input  logic [tmce_pkg::ROW_W-1:0]    row,
    input  logic [tmce_pkg::ROW_W-1:0]    scroll_lines,
    output tmce_pkg::queue_head_t         head,
    input  logic                          pop
);

    localparam logic [tmce_pkg::COL_W:0] COL_LIMIT = (tmce_pkg::COL_W + 1)'(COLUMNS);
    localparam logic [tmce_pkg::ROW_W:0] ROW_LIMIT = (tmce_pkg::ROW_W + 1)'(ROWS);

    tmce_pkg::cmd_t cmd_in;
    tmce_pkg::cmd_t fifo_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push;
    logic           in_range;

    // classify the incoming word
    always_comb
    begin
        in_range = ({1'b0, column} < COL_LIMIT) && ({1'b0, row} < ROW_LIMIT);
        cmd_in.ch       = char_code;
        cmd_in.color    = cell_color;
        cmd_in.col      = column;
        cmd_in.row      = row;
        cmd_in.in_range = in_range;
        cmd_in.lines    = ({1'b0, scroll_lines} > ROW_LIMIT) ?
                          ROW_LIMIT[tmce_pkg::ROW_W-1:0] : scroll_lines;
        case (operation)
            tmce_pkg::OP_PUT_CHAR:
            begin
                if (char_code == tmce_pkg::CHAR_NEWLINE)
                begin
                    cmd_in.kind = tmce_pkg::K_NEWLINE;
                end
                else if (char_code == tmce_pkg::CHAR_BACKSPACE)
                begin
                    cmd_in.kind = tmce_pkg::K_BACKSPACE;
                end
                else
                begin
                    cmd_in.kind = tmce_pkg::K_PUTC;
                end
            end
            tmce_pkg::OP_MOVE_CURSOR: cmd_in.kind = tmce_pkg::K_MOVE;
            tmce_pkg::OP_PUT_AT:      cmd_in.kind = tmce_pkg::K_PUTAT;
            tmce_pkg::OP_CLEAR:       cmd_in.kind = tmce_pkg::K_CLEAR;
            tmce_pkg::OP_SCROLL:      cmd_in.kind = tmce_pkg::K_SCROLL;
            tmce_pkg::OP_READ_CELL:   cmd_in.kind = tmce_pkg::K_READ;
            default:                  cmd_in.kind = tmce_pkg::K_NOP;
        endcase
    end

    // two-entry command queue
    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = fifo_reg[rd_ptr_reg];

endmodule

/* src/tmce_back.sv */
module tmce_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tmce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data,
    input  tmce_pkg::queue_head_t             head,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tmce_pkg::COL_W-1:0]        cursor_column,
    output logic [tmce_pkg::ROW_W-1:0]        cursor_row,
    output logic [tmce_pkg::OFFSET_W-1:0]     cursor_offset,
    output logic [tmce_pkg::CELL_W-1:0]       cell_value
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam logic [CNT_W-1:0] CELLS_CNT = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(CELLS - 1);
    localparam logic [tmce_pkg::COL_W:0]   COL_WRAP = (tmce_pkg::COL_W + 1)'(COLUMNS);
    localparam logic [tmce_pkg::COL_W-1:0] COL_LAST = tmce_pkg::COL_W'(COLUMNS - 1);
    localparam logic [tmce_pkg::ROW_W-1:0] ROW_LAST = tmce_pkg::ROW_W'(ROWS - 1);

    logic [tmce_pkg::CELL_W-1:0] mem [CELLS];
    logic [tmce_pkg::CELL_W-1:0] rd_data_reg;
    logic                        mem_we, mem_re;
    logic [ADDR_W-1:0]           mem_waddr, mem_raddr;
    logic [tmce_pkg::CELL_W-1:0] mem_wdata;

    tmce_pkg::back_state_t state_reg, state_next;
    tmce_pkg::cmd_t        cmd;

    logic [7:0]                  text_color_reg, clear_color_reg;
    logic [tmce_pkg::COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [tmce_pkg::ROW_W-1:0]  cur_line_reg, cur_line_next;
    logic [CNT_W-1:0]            src_ptr_reg, src_ptr_next;
    logic [CNT_W-1:0]            dst_ptr_reg, dst_ptr_next;
    logic                        pend_reg, pend_next;
    logic [tmce_pkg::CELL_W-1:0] fill_data_reg, fill_data_next;
    logic                        out_valid_reg, out_valid_next;
    logic [tmce_pkg::COL_W-1:0]  out_col_reg;
    logic [tmce_pkg::ROW_W-1:0]  out_row_reg;
    logic [tmce_pkg::OFFSET_W-1:0] out_offset_reg;
    logic [tmce_pkg::CELL_W-1:0] out_cell_reg;

    logic                        out_free, go, load;
    logic [tmce_pkg::CELL_W-1:0] load_cell;
    logic [tmce_pkg::COL_W:0]    col_inc;
    logic                        wrap, last_line;
    logic [tmce_pkg::COL_W-1:0]  bs_col;
    logic [tmce_pkg::ROW_W-1:0]  bs_line;
    logic [ADDR_W-1:0]           cur_addr, bs_addr, pos_addr;
    logic [tmce_pkg::OFFSET_W-1:0] offset_next;

    assign cmd      = head.cmd;
    assign out_free = !out_valid_reg || !out_stall;
    assign go       = head.valid && out_free;

    assign col_inc   = {1'b0, cur_col_reg} + 1'b1;
    assign wrap      = (col_inc == COL_WRAP);
    assign last_line = (cur_line_reg == ROW_LAST);

    always_comb
    begin
        bs_col  = cur_col_reg;
        bs_line = cur_line_reg;
        if (cur_col_reg != '0)
        begin
            bs_col = cur_col_reg - 1'b1;
        end
        else if (cur_line_reg != '0)
        begin
            bs_col  = COL_LAST;
            bs_line = cur_line_reg - 1'b1;
        end
    end

    assign cur_addr = ADDR_W'(cur_line_reg * COLUMNS) + ADDR_W'(cur_col_reg);
    assign bs_addr  = ADDR_W'(bs_line * COLUMNS) + ADDR_W'(bs_col);
    assign pos_addr = ADDR_W'(cmd.row * COLUMNS) + ADDR_W'(cmd.col);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg  <= tmce_pkg::COLOR_RESET;
            clear_color_reg <= tmce_pkg::COLOR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tmce_pkg::REG_TEXT_COLOR:  text_color_reg  <= cfg_data;
                tmce_pkg::REG_CLEAR_COLOR: clear_color_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmce_pkg::ST_IDLE:
            begin
                if (go)
                begin
                    case (cmd.kind)
                        tmce_pkg::K_PUTC:
                        begin
                            if (wrap && last_line)
                            begin
                                state_next = tmce_pkg::ST_COPY;
                            end
                        end
                        tmce_pkg::K_NEWLINE:
                        begin
                            if (last_line)
                            begin
                                state_next = tmce_pkg::ST_COPY;
                            end
                        end
                        tmce_pkg::K_CLEAR:
                        begin
                            state_next = tmce_pkg::ST_FILL;
                        end
                        tmce_pkg::K_SCROLL:
                        begin
                            if (cmd.lines != '0)
                            begin
                                state_next = tmce_pkg::ST_COPY;
                            end
                        end
                        tmce_pkg::K_READ:
                        begin
                            if (cmd.in_range)
                            begin
                                state_next = tmce_pkg::ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = tmce_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            tmce_pkg::ST_COPY:
            begin
                if ((src_ptr_reg == CELLS_CNT) && !pend_reg)
                begin
                    state_next = tmce_pkg::ST_FILL;
                end
            end
            tmce_pkg::ST_FILL:
            begin
                if (dst_ptr_reg == LAST_CNT)
                begin
                    state_next = tmce_pkg::ST_DONE;
                end
            end
            tmce_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = tmce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tmce_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cur_col_next   = cur_col_reg;
        cur_line_next  = cur_line_reg;
        src_ptr_next   = src_ptr_reg;
        dst_ptr_next   = dst_ptr_reg;
        pend_next      = pend_reg;
        fill_data_next = fill_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_addr;
        mem_wdata      = {text_color_reg, cmd.ch};
        mem_re         = 1'b0;
        mem_raddr      = pos_addr;
        load           = 1'b0;
        load_cell      = '0;
        case (state_reg)
            tmce_pkg::ST_IDLE:
            begin
                if (go)
                begin
                    case (cmd.kind)
                        tmce_pkg::K_PUTC:
                        begin
                            mem_we = 1'b1;
                            if (!wrap)
                            begin
                                cur_col_next = col_inc[tmce_pkg::COL_W-1:0];
                                load         = 1'b1;
                            end
                            else
                            begin
                                cur_col_next = '0;
                                if (last_line)
                                begin
                                    src_ptr_next   = CNT_W'(COLUMNS);
                                    dst_ptr_next   = '0;
                                    pend_next      = 1'b0;
                                    fill_data_next = '0;
                                end
                                else
                                begin
                                    cur_line_next = cur_line_reg + 1'b1;
                                    load          = 1'b1;
                                end
                            end
                        end
                        tmce_pkg::K_NEWLINE:
                        begin
                            cur_col_next = '0;
                            if (last_line)
                            begin
                                src_ptr_next   = CNT_W'(COLUMNS);
                                dst_ptr_next   = '0;
                                pend_next      = 1'b0;
                                fill_data_next = '0;
                            end
                            else
                            begin
                                cur_line_next = cur_line_reg + 1'b1;
                                load          = 1'b1;
                            end
                        end
                        tmce_pkg::K_BACKSPACE:
                        begin
                            cur_col_next  = bs_col;
                            cur_line_next = bs_line;
                            mem_we        = 1'b1;
                            mem_waddr     = bs_addr;
                            mem_wdata     = {text_color_reg, tmce_pkg::CHAR_SPACE};
                            load          = 1'b1;
                        end
                        tmce_pkg::K_MOVE:
                        begin
                            if (cmd.in_range)
                            begin
                                cur_col_next  = cmd.col;
                                cur_line_next = cmd.row;
                            end
                            load = 1'b1;
                        end
                        tmce_pkg::K_PUTAT:
                        begin
                            mem_we    = cmd.in_range;
                            mem_waddr = pos_addr;
                            mem_wdata = {cmd.color, cmd.ch};
                            load      = 1'b1;
                        end
                        tmce_pkg::K_CLEAR:
                        begin
                            cur_col_next   = '0;
                            cur_line_next  = '0;
                            dst_ptr_next   = '0;
                            fill_data_next = {clear_color_reg, tmce_pkg::CHAR_SPACE};
                        end
                        tmce_pkg::K_SCROLL:
                        begin
                            if (cmd.lines == '0)
                            begin
                                load = 1'b1;
                            end
                            else
                            begin
                                cur_line_next  = (cmd.lines > cur_line_reg) ? '0 :
                                                 cur_line_reg - cmd.lines;
                                src_ptr_next   = CNT_W'(cmd.lines * COLUMNS);
                                dst_ptr_next   = '0;
                                pend_next      = 1'b0;
                                fill_data_next = '0;
                            end
                        end
                        tmce_pkg::K_READ:
                        begin
                            if (cmd.in_range)
                            begin
                                mem_re = 1'b1;
                            end
                            else
                            begin
                                load = 1'b1;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            tmce_pkg::ST_COPY:
            begin
                // read cmd.lines rows ahead (one row for a wrap or newline), write back in the next cycle
                mem_raddr = src_ptr_reg[ADDR_W-1:0];
                if (src_ptr_reg < CELLS_CNT)
                begin
                    mem_re       = 1'b1;
                    src_ptr_next = src_ptr_reg + 1'b1;
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                mem_waddr = dst_ptr_reg[ADDR_W-1:0];
                mem_wdata = rd_data_reg;
                if (pend_reg)
                begin
                    mem_we       = 1'b1;
                    dst_ptr_next = dst_ptr_reg + 1'b1;
                end
            end
            tmce_pkg::ST_FILL:
            begin
                mem_we       = 1'b1;
                mem_waddr    = dst_ptr_reg[ADDR_W-1:0];
                mem_wdata    = fill_data_reg;
                dst_ptr_next = dst_ptr_reg + 1'b1;
            end
            tmce_pkg::ST_DONE:
            begin
                load      = out_free;
                load_cell = (cmd.kind == tmce_pkg::K_READ) ? rd_data_reg : '0;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    assign pop         = load;
    assign offset_next = tmce_pkg::OFFSET_W'(cur_line_next * COLUMNS + cur_col_next);
    assign out_valid_next = load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmce_pkg::ST_IDLE;
            cur_col_reg   <= '0;
            cur_line_reg  <= '0;
            src_ptr_reg   <= '0;
            dst_ptr_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_line_reg  <= cur_line_next;
            src_ptr_reg   <= src_ptr_next;
            dst_ptr_reg   <= dst_ptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_data_reg <= fill_data_next;
        if (load)
        begin
            out_col_reg    <= cur_col_next;
            out_row_reg    <= cur_line_next;
            out_offset_reg <= offset_next;
            out_cell_reg   <= load_cell;
        end
    end

    // screen memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_column = out_col_reg;
    assign cursor_row    = out_row_reg;
    assign cursor_offset = out_offset_reg;
    assign cell_value    = out_cell_reg;

endmodule

/* src/text_mode_console_engine_core.sv */
// channel  dir  handshake              payload
// in       in   in_valid / in_stall    operation char_code cell_color column row scroll_lines
// out      out  out_valid / out_stall  cursor_column cursor_row cursor_offset cell_value
// cfg      in   cfg_write              cfg_index cfg_data
//
// put_char, backspace, move_cursor, put_at and unused codes retire from the back end's idle state;
// read_cell in range adds the done state; clear: the fill state writes one screen cell per cycle
// scroll and a put_char or newline past the bottom row: the copy state moves cells up, the fill
// state zeroes the rest, bound by the single write port of the screen memory
// reset clears cursor, colors (7), queue and output valid; screen contents are not cleared
// a two-word queue keeps taking input while the back end works, until it holds two words; out_stall holds the result
module text_mode_console_engine_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        operation,
    input  logic [7:0]                        char_code,
    input  logic [7:0]                        cell_color,
    input  logic [tmce_pkg::COL_W-1:0]        column,
    input  logic [tmce_pkg::ROW_W-1:0]        row,
    input  logic [tmce_pkg::ROW_W-1:0]        scroll_lines,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tmce_pkg::COL_W-1:0]        cursor_column,
    output logic [tmce_pkg::ROW_W-1:0]        cursor_row,
    output logic [tmce_pkg::OFFSET_W-1:0]     cursor_offset,
    output logic [tmce_pkg::CELL_W-1:0]       cell_value,
    input  logic                              cfg_write,
    input  logic [tmce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data
);

    `include "text_mode_console_engine_core_defines.svh"

    tmce_pkg::queue_head_t head;
    logic                  pop;

    tmce_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .char_code    (char_code),
        .cell_color   (cell_color),
        .column       (column),
        .row          (row),
        .scroll_lines (scroll_lines),
        .head         (head),
        .pop          (pop)
    );

    tmce_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .cursor_offset (cursor_offset),
        .cell_value    (cell_value)
    );

    `TMCE_ASSERT_NOW(a_cursor_range, out_valid, (cursor_column < COLUMNS) && (cursor_row < ROWS), "cursor out of screen")
    `TMCE_ASSERT_NOW(a_offset_match, out_valid, cursor_offset == tmce_pkg::OFFSET_W'(cursor_row * COLUMNS + cursor_column), "cursor offset mismatch")
    `TMCE_ASSERT_NOW(a_pop_nonempty, pop, head.valid, "pop from empty queue")
    `TMCE_ASSERT_NEXT(a_pop_result, pop, out_valid, "retired word gave no result")

endmodule
